/* design/erc_pkg.sv */
// shared types and constants for the elevator request controller
// used by erc_ctrl, erc_datapath and elevator_request_controller; no dependencies
`default_nettype none

package erc_pkg;

	// field widths of the stream beats
	localparam int MODE_W    = 3;
	localparam int FLOOR_W   = 4;
	localparam int EV_W      = 3;
	localparam int PEND_W    = 3;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 16;

	// default car configuration
	localparam int NUM_FLOORS_DEF = 6;
	localparam int LOW_FLOOR      = -1;

	// command modes
	localparam logic [MODE_W-1:0] MODE_REQUEST    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MOVE       = 3'd1;
	localparam logic [MODE_W-1:0] MODE_STOP       = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RESET_STOP = 3'd3;
	localparam logic [MODE_W-1:0] MODE_KEEP_OPEN  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLOSE      = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SENSOR     = 3'd6;

	// result events
	localparam logic [EV_W-1:0] EV_STATUS   = 3'd0;
	localparam logic [EV_W-1:0] EV_ACCEPTED = 3'd1;
	localparam logic [EV_W-1:0] EV_INVALID  = 3'd2;
	localparam logic [EV_W-1:0] EV_DUP      = 3'd3;
	localparam logic [EV_W-1:0] EV_HALTED   = 3'd4;
	localparam logic [EV_W-1:0] EV_PASSED   = 3'd5;
	localparam logic [EV_W-1:0] EV_ARRIVED  = 3'd6;

	// controller to datapath
	typedef struct packed {
		logic apply;   // execute the accepted beat as a single-result command
		logic pop;     // take the queue head as the next target
		logic step;    // move the car one floor toward the target
		logic arrive;  // arrival at the target
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;   // output register can take a result this cycle
		logic in_move;    // incoming beat is a move command
		logic move_go;    // queue not empty and stop flag clear
		logic at_target;  // car stands at the target floor
		logic more;       // queue still holds floors
	} ctl_stat_t;

endpackage

`default_nettype wire

/* design/erc_ctrl.sv */
// sequencer of the elevator request controller: idle, queue pop, floor stepping
// depends on erc_pkg
`default_nettype none

module erc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire erc_pkg::ctl_stat_t stat,
	output erc_pkg::ctl_cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POP  = 2'd1;
	localparam logic [1:0] ST_STEP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = stat.out_free;
				if (in_valid && stat.out_free) begin
					if (stat.in_move && stat.move_go) begin
						state_n = ST_POP;
					end else begin
						cmd.apply = 1'b1;
					end
				end
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_n = ST_STEP;
			end
			ST_STEP: begin
				if (stat.out_free) begin
					if (stat.at_target) begin
						cmd.arrive = 1'b1;
						state_n    = stat.more ? ST_POP : ST_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

`default_nettype wire

/* design/erc_datapath.sv */
// car state, request queue, presence mask and result register
// depends on erc_pkg
`default_nettype none

module erc_datapath #(
	parameter int NUM_FLOORS = erc_pkg::NUM_FLOORS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic [erc_pkg::MODE_W-1:0]            mode,
	input  wire logic signed [erc_pkg::FLOOR_W-1:0]    req_floor,
	input  wire erc_pkg::ctl_cmd_t                     cmd,
	output erc_pkg::ctl_stat_t                         stat,
	input  wire logic                                  out_ready,
	output logic                                       out_valid,
	output logic [erc_pkg::EV_W-1:0]                   event_res,
	output logic signed [erc_pkg::FLOOR_W-1:0]         car_floor,
	output logic                                       moving,
	output logic                                       door_open,
	output logic                                       stop_active,
	output logic                                       hold_open,
	output logic [erc_pkg::PEND_W-1:0]                 pending,
	output logic                                       last
);

	localparam int CNT_W     = $clog2(NUM_FLOORS + 1);
	localparam int PTR_W     = $clog2(NUM_FLOORS);
	localparam int TOP_FLOOR = NUM_FLOORS - 2;

	// queue storage, contents undefined until written
	logic signed [erc_pkg::FLOOR_W-1:0] fifo_q [NUM_FLOORS];

	logic signed [erc_pkg::FLOOR_W-1:0] pos_q, pos_n;
	logic signed [erc_pkg::FLOOR_W-1:0] target_q;
	logic [PTR_W-1:0]                   head_q, head_n;
	logic [CNT_W-1:0]                   count_q, count_n;
	logic [NUM_FLOORS-1:0]              mask_q, mask_n;
	logic                               stop_q, stop_n;
	logic                               door_q, door_n;
	logic                               hold_q, hold_n;

	logic                               in_range;
	logic [PTR_W-1:0]                   req_idx;
	logic [PTR_W-1:0]                   tgt_idx;
	logic [CNT_W:0]                     tail_sum;
	logic [PTR_W-1:0]                   tail;
	logic                               wr_en;
	logic [erc_pkg::EV_W-1:0]           ev_apply;
	logic                               out_free;
	logic                               load;

	assign in_range = (int'(req_floor) >= erc_pkg::LOW_FLOOR) &&
		(int'(req_floor) <= TOP_FLOOR);
	assign req_idx    = PTR_W'(int'(req_floor) - erc_pkg::LOW_FLOOR);
	// presence bit of the floor being served, released on arrival
	assign tgt_idx    = PTR_W'(int'(target_q) - erc_pkg::LOW_FLOOR);
	// tail slot, head plus count wrapped once
	assign tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
	assign tail = (tail_sum >= (CNT_W+1)'(NUM_FLOORS)) ?
		PTR_W'(tail_sum - (CNT_W+1)'(NUM_FLOORS)) : PTR_W'(tail_sum);

	always_comb begin
		pos_n    = pos_q;
		head_n   = head_q;
		count_n  = count_q;
		mask_n   = mask_q;
		stop_n   = stop_q;
		door_n   = door_q;
		hold_n   = hold_q;
		wr_en    = 1'b0;
		ev_apply = erc_pkg::EV_STATUS;
		if (cmd.apply) begin
			unique case (mode)
				erc_pkg::MODE_REQUEST: begin
					if (!in_range) begin
						ev_apply = erc_pkg::EV_INVALID;
					end else if (mask_q[req_idx]) begin
						ev_apply = erc_pkg::EV_DUP;
					end else if (count_q >= CNT_W'(NUM_FLOORS)) begin
						ev_apply = erc_pkg::EV_DUP;
					end else begin
						ev_apply         = erc_pkg::EV_ACCEPTED;
						wr_en            = 1'b1;
						count_n          = count_q + CNT_W'(1);
						mask_n[req_idx]  = 1'b1;
					end
				end
				erc_pkg::MODE_MOVE: begin
					ev_apply = (count_q == '0) ? erc_pkg::EV_STATUS : erc_pkg::EV_HALTED;
				end
				erc_pkg::MODE_STOP: begin
					stop_n = 1'b1;
				end
				erc_pkg::MODE_RESET_STOP: begin
					stop_n = 1'b0;
				end
				erc_pkg::MODE_KEEP_OPEN: begin
					hold_n = 1'b1;
					door_n = 1'b1;
				end
				erc_pkg::MODE_CLOSE: begin
					if (door_q && !hold_q) begin
						door_n = 1'b0;
					end
				end
				erc_pkg::MODE_SENSOR: begin
					if (door_q) begin
						hold_n = 1'b1;
					end
				end
				default: begin
					ev_apply = erc_pkg::EV_STATUS;
				end
			endcase
		end
		if (cmd.pop) begin
			head_n  = (head_q == PTR_W'(NUM_FLOORS - 1)) ? '0 : head_q + PTR_W'(1);
			count_n = count_q - CNT_W'(1);
		end
		if (cmd.step) begin
			pos_n = (pos_q < target_q) ? pos_q + 4'sd1 : pos_q - 4'sd1;
		end
		if (cmd.arrive) begin
			// door opened and closes again unless held
			door_n          = hold_q;
			mask_n[tgt_idx] = 1'b0;
		end
	end

	assign out_free = !out_valid || out_ready;
	assign load     = cmd.apply || cmd.step || cmd.arrive;

	assign stat.out_free  = out_free;
	assign stat.in_move   = (mode == erc_pkg::MODE_MOVE);
	assign stat.move_go   = (count_q != '0) && !stop_q;
	assign stat.at_target = (pos_q == target_q);
	assign stat.more      = (count_q != '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_q[tail] <= req_floor;
		end
		if (cmd.pop) begin
			target_q <= fifo_q[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			head_q  <= '0;
			count_q <= '0;
			mask_q  <= '0;
			stop_q  <= 1'b0;
			door_q  <= 1'b0;
			hold_q  <= 1'b0;
		end else begin
			pos_q   <= pos_n;
			head_q  <= head_n;
			count_q <= count_n;
			mask_q  <= mask_n;
			stop_q  <= stop_n;
			door_q  <= door_n;
			hold_q  <= hold_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			event_res   <= cmd.apply ? ev_apply :
				(cmd.step ? erc_pkg::EV_PASSED : erc_pkg::EV_ARRIVED);
			car_floor   <= pos_n;
			moving      <= cmd.step;
			door_open   <= door_n;
			stop_active <= stop_n;
			hold_open   <= hold_n;
			pending     <= erc_pkg::PEND_W'(count_n);
			last        <= cmd.apply || (cmd.arrive && (count_q == '0));
		end
	end

endmodule

`default_nettype wire

/* design/elevator_request_controller.sv */
// top level of the single-car elevator request controller
// depends on erc_pkg, erc_ctrl and erc_datapath
`default_nettype none

// channel   side    handshake                     payload
// s_axis    in      s_axis_tvalid/s_axis_tready   tuser: mode; tdata: floor
// m_axis    out     m_axis_tvalid/m_axis_tready   tuser: event; tdata: car status; tlast
//
// a single-result command is taken when the result register is free; its result is valid the next cycle
// a move with a non-empty queue and stop clear is taken, then for each queued floor
// the queue is popped, the car steps once per floor travelled and an arrival result follows
// the pace is set by the controller walking the queue one floor per cycle while the output is not stalled
// reset clears car position, queue pointers, presence mask and all flags
// a stalled output holds the result register; the sequencer waits and no beat is taken

module elevator_request_controller #(
	parameter int NUM_FLOORS = erc_pkg::NUM_FLOORS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [erc_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [3:0] floor, rest zero
	input  wire logic [erc_pkg::MODE_W-1:0]       s_axis_tuser,  // [2:0] mode
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [3:0] car_floor, [4] moving, [5] door_open, [6] stop_active,
	// [7] hold_open, [10:8] pending, rest zero
	output logic [erc_pkg::M_TDATA_W-1:0]         m_axis_tdata,
	output logic [erc_pkg::EV_W-1:0]              m_axis_tuser,  // [2:0] event_res
	output logic                                  m_axis_tlast   // last result of the beat
);

	erc_pkg::ctl_cmd_t  cmd;
	erc_pkg::ctl_stat_t stat;

	logic signed [erc_pkg::FLOOR_W-1:0] car_floor;
	logic                               moving;
	logic                               door_open;
	logic                               stop_active;
	logic                               hold_open;
	logic [erc_pkg::PEND_W-1:0]         pending;

	// sequencer: decides when to run a command, pop the queue or step the car
	erc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// car state, queue and result register
	erc_datapath #(
		.NUM_FLOORS (NUM_FLOORS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (s_axis_tuser),
		.req_floor   (s_axis_tdata[erc_pkg::FLOOR_W-1:0]),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.event_res   (m_axis_tuser),
		.car_floor   (car_floor),
		.moving      (moving),
		.door_open   (door_open),
		.stop_active (stop_active),
		.hold_open   (hold_open),
		.pending     (pending),
		.last        (m_axis_tlast)
	);

	// pack the status fields, lowest first
	assign m_axis_tdata = {5'd0, pending, hold_open, stop_active, door_open, moving, car_floor};

	// at most one datapath command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.apply, cmd.pop, cmd.step, cmd.arrive}))
		else $error("more than one datapath command in a cycle");

	// a new beat is only taken while the result register can be loaded
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> stat.out_free)
		else $error("input ready while result register is blocked");

	// the car only steps when it is away from its target
	a_step_target: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !stat.at_target)
		else $error("step issued at target floor");

	// a passed-floor result never closes the beat
	a_moving_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[4]) |-> !m_axis_tlast)
		else $error("moving result marked as last");

endmodule

`default_nettype wire

/* tb/tb_elevator_request_controller.sv */
// self-checking testbench for the elevator request controller
// a car-state predictor class checks every result beat; depends on erc_pkg and the design

// one expected result beat, fields as they leave the block
typedef struct {
	logic [2:0]        ev;
	logic signed [3:0] car_floor;
	logic              moving;
	logic              door_open;
	logic              stop_active;
	logic              hold_open;
	logic [2:0]        pending;
	logic              last;
} car_status_t;

// mirrors the car: position, request ring, presence mask and flags
class car_predictor;
	localparam int NF     = erc_pkg::NUM_FLOORS_DEF;
	localparam int LOW_FL = erc_pkg::LOW_FLOOR;
	localparam int TOP_FL = NF + LOW_FL - 1;

	logic signed [3:0] position;
	logic signed [3:0] ring [NF];
	logic [2:0]        head;
	logic [2:0]        count;
	logic [NF-1:0]     mask;
	logic              stop_flag;
	logic              door_flag;
	logic              hold_flag;

	car_status_t expected_status [$];
	int unsigned commands_seen;
	int unsigned mismatches;

	function new();
		position      = '0;
		head          = '0;
		count         = '0;
		mask          = '0;
		stop_flag     = 1'b0;
		door_flag     = 1'b0;
		hold_flag     = 1'b0;
		commands_seen = 0;
		mismatches    = 0;
	endfunction

	function int outstanding();
		return expected_status.size();
	endfunction

	// snapshot of the car after one result
	function void record(logic [2:0] ev, logic mv, logic lst);
		car_status_t s;
		s.ev          = ev;
		s.car_floor   = position;
		s.moving      = mv;
		s.door_open   = door_flag;
		s.stop_active = stop_flag;
		s.hold_open   = hold_flag;
		s.pending     = count;
		s.last        = lst;
		expected_status.push_back(s);
	endfunction

	// an input beat was taken: advance the car and queue its results
	function void note_command(logic [2:0] mode, logic signed [3:0] fl);
		int f;
		int slot;
		logic signed [3:0] target;
		f = fl;
		commands_seen++;
		case (mode)
			erc_pkg::MODE_REQUEST: begin
				if (f < LOW_FL || f > TOP_FL) begin
					record(erc_pkg::EV_INVALID, 1'b0, 1'b1);
				end else if (mask[f - LOW_FL] || count >= NF) begin
					record(erc_pkg::EV_DUP, 1'b0, 1'b1);
				end else begin
					slot = (int'(head) + int'(count)) % NF;
					ring[slot] = fl;
					count = count + 3'd1;
					mask[f - LOW_FL] = 1'b1;
					record(erc_pkg::EV_ACCEPTED, 1'b0, 1'b1);
				end
			end
			erc_pkg::MODE_MOVE: begin
				if (count == 0) begin
					record(erc_pkg::EV_STATUS, 1'b0, 1'b1);
				end else if (stop_flag) begin
					record(erc_pkg::EV_HALTED, 1'b0, 1'b1);
				end else begin
					while (count != 0) begin
						target = ring[head];
						head   = 3'((int'(head) + 1) % NF);
						count  = count - 3'd1;
						if (int'(target) >= LOW_FL && int'(target) <= TOP_FL)
							mask[int'(target) - LOW_FL] = 1'b0;
						while (position != target) begin
							if (position < target)
								position = position + 4'sd1;
							else
								position = position - 4'sd1;
							record(erc_pkg::EV_PASSED, 1'b1, 1'b0);
						end
						// door opens on arrival and falls shut unless held
						door_flag = hold_flag;
						record(erc_pkg::EV_ARRIVED, 1'b0, count == 0);
					end
				end
			end
			erc_pkg::MODE_STOP: begin
				stop_flag = 1'b1;
				record(erc_pkg::EV_STATUS, 1'b0, 1'b1);
			end
			erc_pkg::MODE_RESET_STOP: begin
				stop_flag = 1'b0;
				record(erc_pkg::EV_STATUS, 1'b0, 1'b1);
			end
			erc_pkg::MODE_KEEP_OPEN: begin
				hold_flag = 1'b1;
				door_flag = 1'b1;
				record(erc_pkg::EV_STATUS, 1'b0, 1'b1);
			end
			erc_pkg::MODE_CLOSE: begin
				if (door_flag && !hold_flag)
					door_flag = 1'b0;
				record(erc_pkg::EV_STATUS, 1'b0, 1'b1);
			end
			erc_pkg::MODE_SENSOR: begin
				if (door_flag)
					hold_flag = 1'b1;
				record(erc_pkg::EV_STATUS, 1'b0, 1'b1);
			end
			default: begin
				record(erc_pkg::EV_STATUS, 1'b0, 1'b1);
			end
		endcase
	endfunction

	function void compare(string name, logic signed [7:0] exp, logic signed [7:0] act);
		if (act !== exp) begin
			$error("%s: expected %0d, actual %0d", name, exp, act);
			mismatches++;
		end
	endfunction

	// a result beat was taken: compare with the oldest expectation
	function void check_beat(logic [2:0] user, logic [15:0] data, logic lst);
		car_status_t s;
		if (expected_status.size() == 0) begin
			$error("result beat with no expectation waiting: event %0d", user);
			mismatches++;
			return;
		end
		s = expected_status.pop_front();
		compare("event_res", s.ev, user);
		compare("car_floor", s.car_floor, $signed(data[3:0]));
		compare("moving", s.moving, data[4]);
		compare("door_open", s.door_open, data[5]);
		compare("stop_active", s.stop_active, data[6]);
		compare("hold_open", s.hold_open, data[7]);
		compare("pending", s.pending, data[10:8]);
		compare("last", s.last, lst);
	endfunction
endclass

module tb_elevator_request_controller;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [erc_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;
	localparam int IDLE_PCT     = 29;
	localparam int HOLD_OFF     = 300;   // long receiver stall, in cycles
	localparam int HOLD_AT      = 60;    // commands seen before the stall starts
	localparam int CALM_FROM    = 400;   // cycle window with no idling on either side
	localparam int CALM_TO      = 1000;
	localparam int WATCHDOG     = 3000;  // cycles with no beat on either side
	localparam int TAIL_CYCLES  = 20;
	localparam int RANDOM_ITEMS = 52;    // per random phase

	logic                          clk;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [erc_pkg::S_TDATA_W-1:0] s_axis_tdata;   // [3:0] floor
	logic [erc_pkg::MODE_W-1:0]    s_axis_tuser;   // [2:0] mode
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	// [3:0] car_floor, [4] moving, [5] door_open, [6] stop_active, [7] hold_open,
	// [10:8] pending
	logic [erc_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic [erc_pkg::EV_W-1:0]      m_axis_tuser;   // [2:0] event_res
	logic                          m_axis_tlast;

	car_predictor book;
	int unsigned  cyc;
	int unsigned  quiet_cycles;
	bit           held_off;

	elevator_request_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cycle count drives the no-idle window
	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	function automatic bit idle_now();
		if (cyc >= CALM_FROM && cyc < CALM_TO)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	// offer one command beat, with random gaps before it
	task automatic send_beat(input logic [erc_pkg::MODE_W-1:0] mode,
		input logic [erc_pkg::FLOOR_W-1:0] fl);
		while (idle_now()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {{(erc_pkg::S_TDATA_W-erc_pkg::FLOOR_W){1'b0}}, fl};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		book.note_command(mode, $signed(fl));
	endtask

	// sender stops until every expected result beat is back
	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (book.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic logic [erc_pkg::FLOOR_W-1:0] any_floor();
		return erc_pkg::FLOOR_W'($urandom_range(15));
	endfunction

	// weighted mix: mostly requests followed by moves, some flag commands and noise
	task automatic random_beats(input int n, input bit allow_keep);
		int r;
		logic [erc_pkg::MODE_W-1:0]  mode;
		logic [erc_pkg::FLOOR_W-1:0] fl;
		for (int i = 0; i < n; i++) begin
			r  = $urandom_range(99);
			fl = any_floor();
			if (r < 45)
				mode = erc_pkg::MODE_REQUEST;
			else if (r < 62)
				mode = erc_pkg::MODE_MOVE;
			else if (r < 69)
				mode = erc_pkg::MODE_STOP;
			else if (r < 79)
				mode = erc_pkg::MODE_RESET_STOP;
			else if (r < 85)
				mode = erc_pkg::MODE_CLOSE;
			else if (r < 91)
				mode = erc_pkg::MODE_SENSOR;
			else if (r < 95)
				mode = MODE_UNUSED;
			else
				mode = allow_keep ? erc_pkg::MODE_KEEP_OPEN : erc_pkg::MODE_REQUEST;
			// requests mostly name a real floor
			if (mode == erc_pkg::MODE_REQUEST && $urandom_range(99) < 80)
				fl = erc_pkg::FLOOR_W'($urandom_range(erc_pkg::NUM_FLOORS_DEF - 1) +
					erc_pkg::LOW_FLOOR);
			send_beat(mode, fl);
		end
	endtask

	// result side: random back-pressure plus one long hold-off
	initial begin
		m_axis_tready = 1'b0;
		held_off      = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				book.check_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
			if (!held_off && book.commands_seen >= HOLD_AT) begin
				// the receiver stalls; the full result register also holds off the input
				held_off = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end
			m_axis_tready <= !idle_now();
		end
	end

	// watchdog on cycles with no beat moving anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG) begin
				$display("FAIL elevator_request_controller");
				$finish;
			end
		end
	end

	// command side and end of run
	initial begin
		book          = new();
		cyc           = 0;
		quiet_cycles  = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, door rules with door closed, unused mode
		send_beat(erc_pkg::MODE_MOVE, any_floor());
		send_beat(erc_pkg::MODE_CLOSE, any_floor());
		send_beat(erc_pkg::MODE_SENSOR, any_floor());
		send_beat(MODE_UNUSED, 4'hf);
		// lowest and highest floors, duplicate, out-of-range extremes and the edge below the lowest floor
		send_beat(erc_pkg::MODE_REQUEST, 4'hf);
		send_beat(erc_pkg::MODE_REQUEST, 4'd4);
		send_beat(erc_pkg::MODE_REQUEST, 4'hf);
		send_beat(erc_pkg::MODE_REQUEST, 4'h8);
		send_beat(erc_pkg::MODE_REQUEST, 4'h7);
		send_beat(erc_pkg::MODE_REQUEST, 4'he);
		// move refused while stopped, queue kept, then served
		send_beat(erc_pkg::MODE_STOP, any_floor());
		send_beat(erc_pkg::MODE_MOVE, any_floor());
		send_beat(erc_pkg::MODE_RESET_STOP, any_floor());
		send_beat(erc_pkg::MODE_MOVE, any_floor());
		// full queue with the longest zig-zag, then a duplicate on a full queue
		send_beat(erc_pkg::MODE_REQUEST, 4'd4);
		send_beat(erc_pkg::MODE_REQUEST, 4'hf);
		send_beat(erc_pkg::MODE_REQUEST, 4'd3);
		send_beat(erc_pkg::MODE_REQUEST, 4'd0);
		send_beat(erc_pkg::MODE_REQUEST, 4'd2);
		send_beat(erc_pkg::MODE_REQUEST, 4'd1);
		send_beat(erc_pkg::MODE_REQUEST, 4'd1);
		send_beat(erc_pkg::MODE_MOVE, any_floor());
		wait_results();

		// door still closes on arrival here
		random_beats(RANDOM_ITEMS, 1'b0);
		wait_results();

		// keep-open latches for the rest of the run
		send_beat(erc_pkg::MODE_KEEP_OPEN, any_floor());
		send_beat(erc_pkg::MODE_CLOSE, any_floor());
		send_beat(erc_pkg::MODE_SENSOR, any_floor());
		send_beat(erc_pkg::MODE_REQUEST, 4'd3);
		send_beat(erc_pkg::MODE_MOVE, any_floor());

		random_beats(RANDOM_ITEMS, 1'b1);
		wait_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (book.mismatches == 0 && book.outstanding() == 0)
			$display("PASS elevator_request_controller");
		else
			$display("FAIL elevator_request_controller");
		$finish;
	end

endmodule

/* files.f */
design/erc_pkg.sv
design/erc_ctrl.sv
design/erc_datapath.sv
design/elevator_request_controller.sv
tb/tb_elevator_request_controller.sv
